// ===== hw/rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helper functions for the pressure compensation
// ----------------------------------------------------------------------------
package bpc_pkg;

    // pipelined divider depth, one quotient bit per stage
    localparam int DIV_STEPS = 32;

    // front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    // compensation constants
    localparam logic signed [31:0] T_ROUND   = 32'sd8;
    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] B3_ROUND  = 32'sd2;
    localparam logic signed [31:0] B4_BIAS   = 32'sd32768;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;
    localparam logic signed [31:0] P_C1      = 32'sd3038;
    localparam logic signed [31:0] P_C2      = -32'sd7357;
    localparam logic signed [31:0] P_C3      = 32'sd3791;
    localparam logic signed [31:0] T_MAX     = 32'sd32767;
    localparam logic signed [31:0] T_MIN     = -32'sd32768;
    localparam logic signed [31:0] P_MAX     = 32'sd1048575;

    // calibration set
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_coef;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [16:0] x1;
        logic signed [17:0] den;
        logic [18:0]        up;
        logic               dz;
    } t_item;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // one stage of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [31:0] dvs;
    } t_div_st;

    // low 32 bits of a product
    function automatic logic signed [31:0] mul_lo(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return a * b;
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                     input logic [4:0] k);
        logic signed [31:0] bias;
        bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (v + bias) >>> k;
    endfunction

    // one restoring division step
    function automatic t_div_st div_step(input t_div_st s);
        t_div_st    r;
        logic [32:0] trial;
        trial = {s.rem, s.num[31]};
        r     = s;
        r.num = {s.num[30:0], 1'b0};
        if (trial >= {1'b0, s.dvs}) begin
            r.rem = 32'(trial - {1'b0, s.dvs});
            r.quo = {s.quo[30:0], 1'b1};
        end else begin
            r.rem = trial[31:0];
            r.quo = {s.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_front
// Accepts raw readings, computes the first temperature term and its divisor,
// flags a zero divisor and pushes the item into the queue
// ----------------------------------------------------------------------------
module bpc_front (
    input  bpc_pkg::t_coef i_coef,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [15:0]    i_raw_temperature,
    input  logic [18:0]    i_raw_pressure,
    input  bpc_pkg::t_qstat i_qstat,
    output logic           o_push,
    output bpc_pkg::t_item o_item
);
    import bpc_pkg::*;

    logic signed [16:0] w_diff;
    logic signed [31:0] w_prod;
    logic signed [31:0] w_x1;

    // handshake: take a transaction whenever the queue has room
    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    // x1 = (ut - ac6) * ac5 / 2^15
    always_comb begin
        w_diff = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_coef.ac6});
        w_prod = mul_lo({{15{w_diff[16]}}, w_diff}, $signed({16'd0, i_coef.ac5}));
        w_x1   = sdiv_pow2(w_prod, 5'd15);
    end

    // classify: divisor x1 + md
    always_comb begin
        o_item.x1  = w_x1[16:0];
        o_item.den = {w_x1[16], w_x1[16:0]} + {{2{i_coef.md[15]}}, i_coef.md};
        o_item.up  = i_raw_pressure;
        o_item.dz  = (o_item.den == 18'sd0);
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_queue
// Short FIFO between the front and the back datapath
// ----------------------------------------------------------------------------
module bpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpc_pkg::t_item  i_item,
    input  logic            i_pop,
    output bpc_pkg::t_item  o_item,
    output bpc_pkg::t_qstat o_qstat
);
    import bpc_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic [Q_AW:0]     n_count;

    assign o_qstat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [31:0] o_quotient
);
    import bpc_pkg::*;

    t_div_st r_st [DIV_STEPS];
    t_div_st n_st [DIV_STEPS];
    t_div_st w_load;

    // first stage starts from the operands
    always_comb begin
        w_load.rem = '0;
        w_load.num = i_dividend;
        w_load.quo = '0;
        w_load.dvs = i_divisor;
    end

    // each stage resolves one bit
    always_comb begin
        n_st[0] = div_step(w_load);
        for (int s = 1; s < DIV_STEPS; s++) begin
            n_st[s] = div_step(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_quotient = r_st[DIV_STEPS-1].quo;

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_back
// Stalling datapath: temperature divide, pressure coefficients, pressure
// divide, final correction and saturation, output register
// ----------------------------------------------------------------------------
module bpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpc_pkg::t_coef     i_coef,
    input  logic               i_q_valid,
    input  bpc_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temperature,
    output logic [19:0]        o_pressure,
    output logic               o_divide_error
);
    import bpc_pkg::*;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic               neg;
        logic signed [16:0] x1;
        logic [18:0]        up;
    } t_side1;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic               hi;
    } t_side2;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic [18:0]        up;
        logic signed [31:0] b6;
        logic signed [31:0] sq;
    } t_stg_ab;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic [18:0]        up;
        logic signed [31:0] m_b2sq;
        logic signed [31:0] m_ac2b6;
        logic signed [31:0] m_ac3b6;
        logic signed [31:0] m_b1sq;
    } t_stg_c;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic [18:0]        up;
        logic signed [31:0] b3;
        logic signed [31:0] x3;
    } t_stg_d;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic [18:0]        up;
        logic signed [31:0] b3;
        logic [16:0]        b4;
    } t_stg_e;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic [31:0]        b7;
        logic [16:0]        b4;
    } t_stg_f;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [15:0] t;
        logic signed [31:0] p;
        logic signed [31:0] ma;
        logic signed [31:0] mb;
    } t_stg_hi;

    logic               w_en;
    t_side1             r_s1 [DIV_STEPS];
    t_side2             r_s2 [DIV_STEPS];
    t_stg_ab            r_a, n_a, r_b, n_b;
    t_stg_c             r_c, n_c;
    t_stg_d             r_d, n_d;
    t_stg_e             r_e, n_e;
    t_stg_f             r_f, n_f;
    t_stg_hi            r_h, n_h, r_i, n_i;
    t_side1             w_s1;
    t_side2             w_s2;
    logic               r_out_valid;
    logic signed [15:0] r_temperature, n_temperature;
    logic [19:0]        r_pressure, n_pressure;
    logic               r_divide_error;

    logic signed [31:0] w_num1, w_den1;
    logic [31:0]        w_div1_a, w_div1_b, w_quo1;
    logic [31:0]        w_div2_a, w_div2_b, w_quo2;
    logic signed [31:0] w_x2, w_b5, w_t;
    logic signed [31:0] w_ac1_4, w_b3pre;
    logic signed [31:0] w_q, w_pd;
    logic signed [31:0] w_x1f, w_sum, w_pf;

    // the whole pipe moves when the output register can take a result
    assign w_en    = !r_out_valid || i_out_ready;
    assign o_q_pop = w_en && i_q_valid;

    // temperature divide operands: mc * 2^11 / (x1 + md), on magnitudes
    always_comb begin
        w_num1   = {{5{i_coef.mc[15]}}, i_coef.mc, 11'd0};
        w_den1   = {{14{i_q_item.den[17]}}, i_q_item.den};
        w_div1_a = w_num1[31] ? 32'(-w_num1) : 32'(w_num1);
        w_div1_b = i_q_item.dz ? 32'd1 : (w_den1[31] ? 32'(-w_den1) : 32'(w_den1));
        w_s1.vld = i_q_valid;
        w_s1.dz  = i_q_item.dz;
        w_s1.neg = w_num1[31] ^ w_den1[31];
        w_s1.x1  = i_q_item.x1;
        w_s1.up  = i_q_item.up;
    end

    bpc_div u_div_t (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_div1_a),
        .i_divisor  (w_div1_b),
        .o_quotient (w_quo1)
    );

    // stage a: b5, temperature, b6 and its square
    always_comb begin
        w_x2 = r_s1[DIV_STEPS-1].neg ? -$signed(w_quo1) : $signed(w_quo1);
        w_b5 = {{15{r_s1[DIV_STEPS-1].x1[16]}}, r_s1[DIV_STEPS-1].x1} + w_x2;
        w_t  = sdiv_pow2(w_b5 + T_ROUND, 5'd4);
        n_a.vld = r_s1[DIV_STEPS-1].vld;
        n_a.dz  = r_s1[DIV_STEPS-1].dz;
        n_a.up  = r_s1[DIV_STEPS-1].up;
        if (w_t > T_MAX) begin
            n_a.t = T_MAX[15:0];
        end else if (w_t < T_MIN) begin
            n_a.t = T_MIN[15:0];
        end else begin
            n_a.t = w_t[15:0];
        end
        n_a.b6 = w_b5 - B6_OFFSET;
        n_a.sq = mul_lo(n_a.b6, n_a.b6);
    end

    // stage b: scale the square
    always_comb begin
        n_b    = r_a;
        n_b.sq = sdiv_pow2(r_a.sq, 5'd12);
    end

    // stage c: coefficient products
    always_comb begin
        n_c.vld     = r_b.vld;
        n_c.dz      = r_b.dz;
        n_c.t       = r_b.t;
        n_c.up      = r_b.up;
        n_c.m_b2sq  = mul_lo({{16{i_coef.b2[15]}}, i_coef.b2}, r_b.sq);
        n_c.m_ac2b6 = mul_lo({{16{i_coef.ac2[15]}}, i_coef.ac2}, r_b.b6);
        n_c.m_ac3b6 = mul_lo({{16{i_coef.ac3[15]}}, i_coef.ac3}, r_b.b6);
        n_c.m_b1sq  = mul_lo({{16{i_coef.b1[15]}}, i_coef.b1}, r_b.sq);
    end

    // stage d: b3 before rounding, x3 for b4
    always_comb begin
        w_ac1_4 = {{14{i_coef.ac1[15]}}, i_coef.ac1, 2'd0};
        w_b3pre = (w_ac1_4 + sdiv_pow2(r_c.m_b2sq, 5'd11)
                  + sdiv_pow2(r_c.m_ac2b6, 5'd11)) <<< i_coef.oss;
        n_d.vld = r_c.vld;
        n_d.dz  = r_c.dz;
        n_d.t   = r_c.t;
        n_d.up  = r_c.up;
        n_d.b3  = w_b3pre;
        n_d.x3  = sdiv_pow2(sdiv_pow2(r_c.m_ac3b6, 5'd13) + sdiv_pow2(r_c.m_b1sq, 5'd16)
                  + B3_ROUND, 5'd2);
    end

    // stage e: b3 and b4
    always_comb begin
        logic signed [31:0] prod;
        prod    = mul_lo($signed({16'd0, i_coef.ac4}), r_d.x3 + B4_BIAS);
        n_e.vld = r_d.vld;
        n_e.dz  = r_d.dz;
        n_e.t   = r_d.t;
        n_e.up  = r_d.up;
        n_e.b3  = sdiv_pow2(r_d.b3 + B3_ROUND, 5'd2);
        n_e.b4  = prod[31:15];
    end

    // stage f: b7, second zero-divisor check
    always_comb begin
        n_f.vld = r_e.vld;
        n_f.dz  = r_e.dz || (r_e.b4 == 17'd0);
        n_f.t   = r_e.t;
        n_f.b4  = r_e.b4;
        n_f.b7  = 32'(mul_lo($signed({13'd0, r_e.up} - 32'(r_e.b3)),
                             $signed({16'd0, B7_SCALE >> i_coef.oss})));
    end

    // pressure divide operands: b7*2/b4 or (b7/b4)*2
    always_comb begin
        w_div2_a = r_f.b7[31] ? r_f.b7 : {r_f.b7[30:0], 1'b0};
        w_div2_b = r_f.dz ? 32'd1 : {15'd0, r_f.b4};
        w_s2.vld = r_f.vld;
        w_s2.dz  = r_f.dz;
        w_s2.t   = r_f.t;
        w_s2.hi  = r_f.b7[31];
    end

    bpc_div u_div_p (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_div2_a),
        .i_divisor  (w_div2_b),
        .o_quotient (w_quo2)
    );

    // stage h: raw pressure, first correction products
    always_comb begin
        w_q     = r_s2[DIV_STEPS-1].hi ? $signed({w_quo2[30:0], 1'b0}) : $signed(w_quo2);
        w_pd    = sdiv_pow2(w_q, 5'd8);
        n_h.vld = r_s2[DIV_STEPS-1].vld;
        n_h.dz  = r_s2[DIV_STEPS-1].dz;
        n_h.t   = r_s2[DIV_STEPS-1].t;
        n_h.p   = w_q;
        n_h.ma  = mul_lo(w_pd, w_pd);
        n_h.mb  = mul_lo(P_C2, w_q);
    end

    // stage i: second correction product
    always_comb begin
        n_i    = r_h;
        n_i.ma = mul_lo(r_h.ma, P_C1);
        n_i.mb = sdiv_pow2(r_h.mb, 5'd16);
    end

    // final sum and saturation; a zero divisor gives zero results
    always_comb begin
        w_x1f = sdiv_pow2(r_i.ma, 5'd16);
        w_sum = w_x1f + r_i.mb + P_C3;
        w_pf  = r_i.p + sdiv_pow2(w_sum, 5'd4);
        if (r_i.dz) begin
            n_temperature = '0;
            n_pressure    = '0;
        end else begin
            n_temperature = r_i.t;
            if (w_pf[31]) begin
                n_pressure = '0;
            end else if (w_pf > P_MAX) begin
                n_pressure = P_MAX[19:0];
            end else begin
                n_pressure = w_pf[19:0];
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_s1[k].vld <= 1'b0;
                r_s2[k].vld <= 1'b0;
            end
            r_a.vld     <= 1'b0;
            r_b.vld     <= 1'b0;
            r_c.vld     <= 1'b0;
            r_d.vld     <= 1'b0;
            r_e.vld     <= 1'b0;
            r_f.vld     <= 1'b0;
            r_h.vld     <= 1'b0;
            r_i.vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1[0] <= w_s1;
            r_s2[0] <= w_s2;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_s1[k] <= r_s1[k-1];
                r_s2[k] <= r_s2[k-1];
            end
            r_a            <= n_a;
            r_b            <= n_b;
            r_c            <= n_c;
            r_d            <= n_d;
            r_e            <= n_e;
            r_f            <= n_f;
            r_h            <= n_h;
            r_i            <= n_i;
            r_out_valid    <= r_i.vld;
            r_temperature  <= n_temperature;
            r_pressure     <= n_pressure;
            r_divide_error <= r_i.dz;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_temperature  = r_temperature;
    assign o_pressure     = r_pressure;
    assign o_divide_error = r_divide_error;

endmodule
`default_nettype wire

// ===== hw/rtl/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor
// ----------------------------------------------------------------------------
// Usage:
//   Load the five calibration words and the oversampling setting through the
//   configuration channel (index, data, valid/ready; always ready) while no
//   transaction is in flight. Each input transaction carries one raw
//   temperature and one raw pressure word; each output transaction returns
//   temperature in 0.1 degC, pressure in Pa and a divide-error flag.
//   A zero divisor gives zero results with the flag set; results saturate.
// Throughput: one transaction per cycle, sustained while the receiver takes
//   results. The two 32-stage pipelined dividers set the depth.
// Path: with an empty queue an input passes the queue, both dividers, the
//   8 arithmetic stages and the output register before output valid.
// Stall: the datapath holds while a result waits in the output register; the
//   four-entry queue keeps accepting input until it is full.
// Reset: synchronous, active low; clears the calibration registers to zero,
//   empties the queue and drops all in-flight valid bits.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [18:0]        i_raw_pressure,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temperature,
    output logic [19:0]        o_pressure,
    output logic               o_divide_error
);
    import bpc_pkg::*;

    t_coef  r_coef;
    t_item  w_front_item;
    t_item  w_q_item;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AC1_AC2: begin
                    r_coef.ac1 <= i_cfg_data[31:16];
                    r_coef.ac2 <= i_cfg_data[15:0];
                end
                REG_AC3_AC4: begin
                    r_coef.ac3 <= i_cfg_data[31:16];
                    r_coef.ac4 <= i_cfg_data[15:0];
                end
                REG_AC5_AC6: begin
                    r_coef.ac5 <= i_cfg_data[31:16];
                    r_coef.ac6 <= i_cfg_data[15:0];
                end
                REG_B1_B2: begin
                    r_coef.b1 <= i_cfg_data[31:16];
                    r_coef.b2 <= i_cfg_data[15:0];
                end
                REG_MC_MD: begin
                    r_coef.mc <= i_cfg_data[31:16];
                    r_coef.md <= i_cfg_data[15:0];
                end
                REG_OSS: begin
                    r_coef.oss <= i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    bpc_front u_front (
        .i_coef            (r_coef),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_qstat           (w_qstat),
        .o_push            (w_push),
        .o_item            (w_front_item)
    );

    // decoupling queue
    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_qstat (w_qstat)
    );

    // back: datapath and output register
    bpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_coef         (r_coef),
        .i_q_valid      (!w_qstat.empty),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_temperature  (o_temperature),
        .o_pressure     (o_pressure),
        .o_divide_error (o_divide_error)
    );

    // a flagged result carries zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> (o_temperature == 16'sd0 && o_pressure == 20'd0))
        else $error("divide error with nonzero result");

    // a stalled result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("stalled result lost");

    // queue is never full and empty at once
    a_qstat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue status inconsistent");

    // no pop from an empty queue
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
